/* hw/rtl/mobile_base_odometry_slew_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mobile base odometry block
// Overlapping and next-cycle implications, clocked and disabled under reset.
// ----------------------------------------------------------------------------
`ifndef MOBILE_BASE_ODOMETRY_SLEW_ASSERT_SVH
`define MOBILE_BASE_ODOMETRY_SLEW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBOS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbos assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MBOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbos assertion failed");

`endif

/* hw/rtl/mbos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_pkg
// Shared widths, configuration layout and register codes of the odometry block.
// ----------------------------------------------------------------------------
package mbos_pkg;

    localparam int LIN_W  = 18;
    localparam int ANG_W  = 24;
    localparam int POS_W  = 48;
    localparam int HEAD_W = 32;
    localparam int TIME_W = 32;
    localparam int LACC_W = 16;
    localparam int AACC_W = 24;
    localparam int TMO_W  = 16;
    localparam int DT_W   = 16;
    localparam int TRIG_W = 31;

    // Shared shift-add multiplier: signed multiplicand, unsigned multiplier.
    localparam int MUL_AW = 35;
    localparam int MUL_BW = 31;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] CFG_LIN_ACCEL = 2'd0;
    localparam logic [1:0] CFG_ANG_ACCEL = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [LACC_W-1:0] LIN_ACCEL_RESET = 16'd1024;
    localparam logic [AACC_W-1:0] ANG_ACCEL_RESET = 24'd4194304;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET   = 16'd512;

    typedef struct packed {
        logic [LACC_W-1:0] lin_accel;
        logic [AACC_W-1:0] ang_accel;
        logic [TMO_W-1:0]  timeout;
    } cfg_t;

endpackage

/* hw/rtl/mbos_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_in_if / mbos_out_if
// Valid/ready channels for items entering and results leaving the block.
// ----------------------------------------------------------------------------
interface mbos_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [mbos_pkg::TIME_W-1:0]           timestamp;
    logic signed [mbos_pkg::LIN_W-1:0]     target_linear;
    logic signed [mbos_pkg::ANG_W-1:0]     target_angular;

    modport source (output valid, kind, timestamp, target_linear, target_angular,
                    input ready);
    modport sink (input valid, kind, timestamp, target_linear, target_angular,
                  output ready);
endinterface

interface mbos_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mbos_pkg::POS_W-1:0]     pos_x;
    logic signed [mbos_pkg::POS_W-1:0]     pos_y;
    logic [mbos_pkg::HEAD_W-1:0]           heading;
    logic signed [mbos_pkg::LIN_W-1:0]     linear_velocity;
    logic signed [mbos_pkg::ANG_W-1:0]     angular_velocity;
    logic                                  timed_out;

    modport source (output valid, pos_x, pos_y, heading, linear_velocity,
                    angular_velocity, timed_out, input ready);
    modport sink (input valid, pos_x, pos_y, heading, linear_velocity,
                  angular_velocity, timed_out, output ready);
endinterface

/* hw/rtl/mbos_serial_mult.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_serial_mult
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mbos_serial_mult (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mbos_pkg::MUL_AW-1:0]        a,
    input  logic [mbos_pkg::MUL_BW-1:0]        b,
    output logic                               done,
    output logic [mbos_pkg::MUL_PW-1:0]        product
);
    localparam int AW    = mbos_pkg::MUL_AW;
    localparam int BW    = mbos_pkg::MUL_BW;
    localparam int CNT_W = $clog2(BW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    a_reg;
    logic [AW:0]      hi_reg;
    logic [BW-1:0]    lo_reg;
    logic [AW:0]      addend;
    logic [AW:0]      sum;

    // The partial product shifts right; the multiplier bits leave at the bottom.
    assign addend = lo_reg[0] ? {a_reg[AW-1], a_reg} : '0;
    assign sum    = hi_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[AW], sum[AW:1]};
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg[AW-1:0], lo_reg};

endmodule

/* hw/rtl/mbos_trig_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_trig_rom
// Quarter-wave Q30 sine table with a registered read port.
// ----------------------------------------------------------------------------
module mbos_trig_rom #(
    parameter int ANGLE_INDEX_BITS = 10
) (
    input  logic                              clk,
    input  logic [ANGLE_INDEX_BITS-2:0]       addr,
    output logic [mbos_pkg::TRIG_W-1:0]       data
);
    localparam int QDEPTH = (1 << (ANGLE_INDEX_BITS - 2)) + 1;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [mbos_pkg::TRIG_W-1:0] rom_word_t;
    typedef rom_word_t rom_arr_t [QDEPTH];

    // Odd Horner series up to the eleventh power, truncating at every step.
    function automatic rom_word_t quarter_sine(input longint unsigned r);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned t;
        longint unsigned s;
        ang  = (r * HALF_PI_Q30) >> 30;
        ang2 = (ang * ang) >> 30;
        t    = Q30_ONE;
        t    = Q30_ONE - ((ang2 * t) >> 30) / 110;
        t    = Q30_ONE - ((ang2 * t) >> 30) / 72;
        t    = Q30_ONE - ((ang2 * t) >> 30) / 42;
        t    = Q30_ONE - ((ang2 * t) >> 30) / 20;
        t    = Q30_ONE - ((ang2 * t) >> 30) / 6;
        s    = (ang * t) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return rom_word_t'(s);
    endfunction

    function automatic rom_arr_t build_table();
        rom_arr_t tbl;
        for (int i = 0; i < QDEPTH; i++)
        begin
            tbl[i] = quarter_sine(64'(i) << (32 - ANGLE_INDEX_BITS));
        end
        return tbl;
    endfunction

    localparam rom_arr_t SINE_TABLE = build_table();

    logic [mbos_pkg::TRIG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_TABLE[addr];
    end

    assign data = data_reg;

endmodule

/* hw/rtl/mbos_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_cfg_regs
// APB register bank: acceleration limits and command timeout.
// ----------------------------------------------------------------------------
module mbos_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbos_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mbos_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mbos_pkg::CFG_DATA_W-1:0]     prdata,
    output mbos_pkg::cfg_t                      cfg
);
    mbos_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_sel;
    logic           wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lin_accel <= mbos_pkg::LIN_ACCEL_RESET;
            cfg_reg.ang_accel <= mbos_pkg::ANG_ACCEL_RESET;
            cfg_reg.timeout   <= mbos_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mbos_pkg::CFG_LIN_ACCEL: cfg_reg.lin_accel <= pwdata[mbos_pkg::LACC_W-1:0];
                mbos_pkg::CFG_ANG_ACCEL: cfg_reg.ang_accel <= pwdata[mbos_pkg::AACC_W-1:0];
                mbos_pkg::CFG_TIMEOUT:   cfg_reg.timeout   <= pwdata[mbos_pkg::TMO_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mbos_pkg::CFG_LIN_ACCEL: prdata = 32'(cfg_reg.lin_accel);
            mbos_pkg::CFG_ANG_ACCEL: prdata = 32'(cfg_reg.ang_accel);
            mbos_pkg::CFG_TIMEOUT:   prdata = 32'(cfg_reg.timeout);
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/mobile_base_odometry_slew.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mobile_base_odometry_slew
// Simulated unicycle base: slew-limited velocity commands and dead reckoning.
// ----------------------------------------------------------------------------
// One item is processed at a time. Every product goes through one shared
// bit-serial multiplier that retires one multiplier bit per cycle (31 bits per
// product), two products for a command and four for a tick, plus sine table
// reads in states S_ROM0 to S_ROM2 on a tick. A finished result waits in the
// output register, and the next item is accepted while it waits.
module mobile_base_odometry_slew #(
    parameter int ANGLE_INDEX_BITS = 10,
    parameter int COMMAND_DT_CAP   = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mbos_in_if.sink                             in_ch,
    mbos_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbos_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mbos_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mbos_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    localparam int QIDX_W  = ANGLE_INDEX_BITS - 2;
    localparam int RADDR_W = ANGLE_INDEX_BITS - 1;
    localparam int QUARTER = 1 << QIDX_W;
    localparam int LIN_W   = mbos_pkg::LIN_W;
    localparam int ANG_W   = mbos_pkg::ANG_W;
    localparam int POS_W   = mbos_pkg::POS_W;
    localparam int AW      = mbos_pkg::MUL_AW;
    localparam int BW      = mbos_pkg::MUL_BW;
    localparam int PW      = mbos_pkg::MUL_PW;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_LSTEP, S_ASTEP, S_SLEW, S_PMUL, S_HMUL,
        S_ROM0, S_ROM1, S_ROM2, S_XMUL, S_YPOS, S_FINISH
    } state_t;

    mbos_pkg::cfg_t cfg;

    state_t                        state_reg;
    logic                          issued_reg;
    logic                          kind_reg;
    logic [31:0]                   now_reg;
    logic signed [LIN_W-1:0]       tl_reg;
    logic signed [ANG_W-1:0]       ta_reg;
    logic [mbos_pkg::DT_W-1:0]     dt_reg;
    logic [21:0]                   step_lin_reg;
    logic [29:0]                   step_ang_reg;
    logic signed [33:0]            p_reg;
    logic [31:0]                   yaw_inc_reg;
    logic [mbos_pkg::TRIG_W-1:0]   s_mag_reg;
    logic [mbos_pkg::TRIG_W-1:0]   sin_mag_reg;
    logic [mbos_pkg::TRIG_W-1:0]   cos_mag_reg;
    logic                          sin_neg_reg;
    logic                          cos_neg_reg;

    logic signed [LIN_W-1:0]       cur_lin_reg;
    logic signed [ANG_W-1:0]       cur_ang_reg;
    logic [POS_W-1:0]              x_reg;
    logic [POS_W-1:0]              y_reg;
    logic [31:0]                   yaw_reg;
    logic [31:0]                   last_cmd_reg;
    logic [31:0]                   last_tick_reg;
    logic                          latch_reg;

    logic                          out_valid_reg;
    logic [POS_W-1:0]              out_x_reg;
    logic [POS_W-1:0]              out_y_reg;
    logic [31:0]                   out_head_reg;
    logic [LIN_W-1:0]              out_lin_reg;
    logic [ANG_W-1:0]              out_ang_reg;
    logic                          out_tmo_reg;

    logic                          mul_state;
    logic                          mul_start;
    logic                          mul_done;
    logic [AW-1:0]                 mul_a;
    logic [BW-1:0]                 mul_b;
    logic [PW-1:0]                 mul_p;
    logic [AW-1:0]                 p_ext;

    logic [RADDR_W-1:0]            addr_s;
    logic [RADDR_W-1:0]            addr_c;
    logic [RADDR_W-1:0]            rom_addr;
    logic [mbos_pkg::TRIG_W-1:0]   rom_data;
    logic [1:0]                    quad;

    logic [31:0]                   cmd_gap;
    logic [31:0]                   tick_gap;

    logic [LIN_W:0]                dl;
    logic [LIN_W:0]                dl_mag;
    logic [22:0]                   lin_up;
    logic [22:0]                   lin_dn;
    logic [LIN_W-1:0]              lin_slew;
    logic [ANG_W:0]                da;
    logic [ANG_W:0]                da_mag;
    logic [30:0]                   ang_up;
    logic [30:0]                   ang_dn;
    logic [ANG_W-1:0]              ang_slew;

    mbos_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );
    assign pready = 1'b1;

    mbos_serial_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    mbos_trig_rom #(
        .ANGLE_INDEX_BITS (ANGLE_INDEX_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // The table holds one quarter wave; cosine reads the mirrored entry.
    assign quad     = yaw_reg[31:30];
    assign addr_s   = {1'b0, yaw_reg[29 -: QIDX_W]};
    assign addr_c   = RADDR_W'(QUARTER) - addr_s;
    assign rom_addr = (state_reg == S_ROM0) ? addr_s : addr_c;

    assign cmd_gap  = now_reg - last_cmd_reg;
    assign tick_gap = now_reg - last_tick_reg;

    assign p_ext = {{(AW-34){p_reg[33]}}, p_reg};

    assign mul_state = (state_reg == S_LSTEP) || (state_reg == S_ASTEP) ||
                       (state_reg == S_PMUL)  || (state_reg == S_HMUL)  ||
                       (state_reg == S_XMUL)  || (state_reg == S_YPOS);
    assign mul_start = mul_state && !issued_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = BW'(dt_reg);
        case (state_reg)
            S_LSTEP: mul_a = AW'(cfg.lin_accel);
            S_ASTEP: mul_a = AW'(cfg.ang_accel);
            S_PMUL:  mul_a = {{(AW-LIN_W){cur_lin_reg[LIN_W-1]}}, cur_lin_reg};
            S_HMUL:  mul_a = {{(AW-ANG_W){cur_ang_reg[ANG_W-1]}}, cur_ang_reg};
            S_XMUL:
            begin
                // Negating the multiplicand keeps the later floor shift exact.
                mul_a = cos_neg_reg ? -p_ext : p_ext;
                mul_b = cos_mag_reg;
            end
            S_YPOS:
            begin
                mul_a = sin_neg_reg ? -p_ext : p_ext;
                mul_b = sin_mag_reg;
            end
            default: mul_a = '0;
        endcase
    end

    // Slew toward the command target by at most one step.
    always_comb
    begin
        dl     = {tl_reg[LIN_W-1], tl_reg} - {cur_lin_reg[LIN_W-1], cur_lin_reg};
        dl_mag = dl[LIN_W] ? (~dl + 1'b1) : dl;
        lin_up = {{(23-LIN_W){cur_lin_reg[LIN_W-1]}}, cur_lin_reg} + {1'b0, step_lin_reg};
        lin_dn = {{(23-LIN_W){cur_lin_reg[LIN_W-1]}}, cur_lin_reg} - {1'b0, step_lin_reg};
        if ({3'b0, dl_mag} > step_lin_reg)
        begin
            lin_slew = dl[LIN_W] ? lin_dn[LIN_W-1:0] : lin_up[LIN_W-1:0];
        end
        else
        begin
            lin_slew = tl_reg;
        end

        da     = {ta_reg[ANG_W-1], ta_reg} - {cur_ang_reg[ANG_W-1], cur_ang_reg};
        da_mag = da[ANG_W] ? (~da + 1'b1) : da;
        ang_up = {{(31-ANG_W){cur_ang_reg[ANG_W-1]}}, cur_ang_reg} + {1'b0, step_ang_reg};
        ang_dn = {{(31-ANG_W){cur_ang_reg[ANG_W-1]}}, cur_ang_reg} - {1'b0, step_ang_reg};
        if ({5'b0, da_mag} > step_ang_reg)
        begin
            ang_slew = da[ANG_W] ? ang_dn[ANG_W-1:0] : ang_up[ANG_W-1:0];
        end
        else
        begin
            ang_slew = ta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            kind_reg      <= 1'b0;
            now_reg       <= '0;
            tl_reg        <= '0;
            ta_reg        <= '0;
            dt_reg        <= '0;
            step_lin_reg  <= '0;
            step_ang_reg  <= '0;
            p_reg         <= '0;
            yaw_inc_reg   <= '0;
            s_mag_reg     <= '0;
            sin_mag_reg   <= '0;
            cos_mag_reg   <= '0;
            sin_neg_reg   <= 1'b0;
            cos_neg_reg   <= 1'b0;
            cur_lin_reg   <= '0;
            cur_ang_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            yaw_reg       <= '0;
            last_cmd_reg  <= '0;
            last_tick_reg <= '0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_head_reg  <= '0;
            out_lin_reg   <= '0;
            out_ang_reg   <= '0;
            out_tmo_reg   <= 1'b0;
        end
        else
        begin
            // In the finish state the output register is either reloaded or held.
            if (out_valid_reg && out_ch.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            if (mul_state)
            begin
                issued_reg <= !mul_done;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        kind_reg  <= in_ch.kind;
                        now_reg   <= in_ch.timestamp;
                        tl_reg    <= in_ch.target_linear;
                        ta_reg    <= in_ch.target_angular;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (!kind_reg)
                    begin
                        dt_reg    <= (cmd_gap > 32'(COMMAND_DT_CAP)) ?
                                     mbos_pkg::DT_W'(COMMAND_DT_CAP) : cmd_gap[15:0];
                        state_reg <= S_LSTEP;
                    end
                    else
                    begin
                        // Velocities drop to zero only on entry into timeout.
                        if (cmd_gap > 32'(cfg.timeout))
                        begin
                            if (!latch_reg)
                            begin
                                cur_lin_reg <= '0;
                                cur_ang_reg <= '0;
                            end
                            latch_reg <= 1'b1;
                        end
                        else
                        begin
                            latch_reg <= 1'b0;
                        end
                        dt_reg    <= (|tick_gap[31:16]) ? 16'hFFFF : tick_gap[15:0];
                        state_reg <= S_PMUL;
                    end
                end
                S_LSTEP:
                begin
                    if (mul_done)
                    begin
                        step_lin_reg <= mul_p[31:10];
                        state_reg    <= S_ASTEP;
                    end
                end
                S_ASTEP:
                begin
                    if (mul_done)
                    begin
                        step_ang_reg <= mul_p[39:10];
                        state_reg    <= S_SLEW;
                    end
                end
                S_SLEW:
                begin
                    cur_lin_reg  <= lin_slew;
                    cur_ang_reg  <= ang_slew;
                    last_cmd_reg <= now_reg;
                    state_reg    <= S_FINISH;
                end
                S_PMUL:
                begin
                    if (mul_done)
                    begin
                        p_reg     <= mul_p[33:0];
                        state_reg <= S_HMUL;
                    end
                end
                S_HMUL:
                begin
                    if (mul_done)
                    begin
                        yaw_inc_reg <= mul_p[31:0];
                        state_reg   <= S_ROM0;
                    end
                end
                S_ROM0:
                begin
                    state_reg <= S_ROM1;
                end
                S_ROM1:
                begin
                    s_mag_reg <= rom_data;
                    state_reg <= S_ROM2;
                end
                S_ROM2:
                begin
                    sin_mag_reg <= quad[0] ? rom_data : s_mag_reg;
                    cos_mag_reg <= quad[0] ? s_mag_reg : rom_data;
                    sin_neg_reg <= quad[1];
                    cos_neg_reg <= quad[1] ^ quad[0];
                    state_reg   <= S_XMUL;
                end
                S_XMUL:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= x_reg + {{(POS_W-36){mul_p[PW-1]}}, mul_p[PW-1:30]};
                        state_reg <= S_YPOS;
                    end
                end
                S_YPOS:
                begin
                    if (mul_done)
                    begin
                        y_reg         <= y_reg + {{(POS_W-36){mul_p[PW-1]}}, mul_p[PW-1:30]};
                        yaw_reg       <= yaw_reg + yaw_inc_reg;
                        last_tick_reg <= now_reg;
                        state_reg     <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= x_reg;
                        out_y_reg     <= y_reg;
                        out_head_reg  <= yaw_reg;
                        out_lin_reg   <= cur_lin_reg;
                        out_ang_reg   <= cur_ang_reg;
                        out_tmo_reg   <= latch_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready             = (state_reg == S_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.pos_x            = out_x_reg;
    assign out_ch.pos_y            = out_y_reg;
    assign out_ch.heading          = out_head_reg;
    assign out_ch.linear_velocity  = out_lin_reg;
    assign out_ch.angular_velocity = out_ang_reg;
    assign out_ch.timed_out        = out_tmo_reg;

endmodule

/* hw/rtl/mbos_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbos_checker
// Port-level checks on the odometry block's item and result channels.
// ----------------------------------------------------------------------------
`include "mobile_base_odometry_slew_assert.svh"

module mbos_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [mbos_pkg::POS_W-1:0]         out_pos_x,
    input logic [mbos_pkg::HEAD_W-1:0]        out_heading
);
    // An accepted item keeps the block busy for at least the next cycle.
    `MBOS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // A new result appears only as the block returns to waiting for input.
    `MBOS_ASSERT_SAME(a_result_frees_input, clk, rst_n, $rose(out_valid), in_ready)
    `MBOS_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `MBOS_ASSERT_NEXT(a_out_data_holds, clk, rst_n, out_valid && !out_ready, $stable(out_pos_x) && $stable(out_heading))

endmodule

bind mobile_base_odometry_slew mbos_checker u_mbos_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pos_x   (out_ch.pos_x),
    .out_heading (out_ch.heading)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slew-limited odometry block. Velocity commands
// and simulation ticks go in over a valid/ready channel and are predicted
// bit-exactly here. Every result is compared field by field with the oldest
// predicted one. Runs cover several acceleration and timeout settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ANGLE_BITS = 10;
    localparam int DT_CAP     = 512;

    typedef struct {
        logic signed [mbos_pkg::POS_W-1:0]  x;
        logic signed [mbos_pkg::POS_W-1:0]  y;
        logic [mbos_pkg::HEAD_W-1:0]        hd;
        logic signed [mbos_pkg::LIN_W-1:0]  lin;
        logic signed [mbos_pkg::ANG_W-1:0]  ang;
        logic                               tmo;
    } odom_t;

    class odom_scoreboard;
        odom_t           pending_q[$];
        int              errors;
        int              n_cmd;
        int              n_tick;
        int              n_tmo;
        bit [15:0]       lin_acc;
        bit [23:0]       ang_acc;
        bit [15:0]       tmo_lim;
        longint          lin_v;
        longint          ang_v;
        bit [47:0]       xa;
        bit [47:0]       ya;
        bit [31:0]       yaw;
        bit [31:0]       t_cmd;
        bit [31:0]       t_tick;
        bit              latch;

        function new();
            lin_acc = mbos_pkg::LIN_ACCEL_RESET;
            ang_acc = mbos_pkg::ANG_ACCEL_RESET;
            tmo_lim = mbos_pkg::TIMEOUT_RESET;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] val);
            if (idx == mbos_pkg::CFG_LIN_ACCEL)
                lin_acc = val[15:0];
            else if (idx == mbos_pkg::CFG_ANG_ACCEL)
                ang_acc = val[23:0];
            else if (idx == mbos_pkg::CFG_TIMEOUT)
                tmo_lim = val[15:0];
        endfunction

        // Q30 sine of r/2^30 quarter turns from the truncated Horner series.
        function longint quarter_sine(bit [63:0] r);
            bit [63:0] a;
            bit [63:0] a2;
            bit [63:0] t;
            bit [63:0] s;
            bit [63:0] divs [5];
            divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
            a  = (r * 64'd1686629713) >> 30;
            a2 = (a * a) >> 30;
            t  = 64'd1 << 30;
            for (int k = 0; k < 5; k++)
                t = (64'd1 << 30) - ((a2 * t) >> 30) / divs[k];
            s = (a * t) >> 30;
            if (s > (64'd1 << 30))
                s = 64'd1 << 30;
            return longint'(s);
        endfunction

        function longint slew(longint cur, longint tgt, longint step);
            longint d;
            longint ad;
            d  = tgt - cur;
            ad = (d < 0) ? -d : d;
            if (ad > step)
                return (d > 0) ? cur + step : cur - step;
            return tgt;
        endfunction

        function void note_item(bit kind, bit [31:0] ts, bit [17:0] tl, bit [23:0] ta);
            bit [31:0] dt32;
            bit [31:0] phase;
            longint    dt;
            longint    p;
            longint    s;
            longint    c;
            longint    sn;
            longint    cs;
            longint    yaw_step;
            odom_t     r;
            if (kind == 1'b0) begin
                n_cmd++;
                dt32 = ts - t_cmd;
                dt = (dt32 > DT_CAP) ? DT_CAP : longint'(dt32);
                lin_v = slew(lin_v, longint'($signed(tl)), (longint'(lin_acc) * dt) >>> 10);
                ang_v = slew(ang_v, longint'($signed(ta)), (longint'(ang_acc) * dt) >>> 10);
                t_cmd = ts;
            end else begin
                n_tick++;
                if (ts - t_cmd > {16'd0, tmo_lim}) begin
                    if (!latch) begin
                        lin_v = 0;
                        ang_v = 0;
                        n_tmo++;
                    end
                    latch = 1'b1;
                end else begin
                    latch = 1'b0;
                end
                dt32 = ts - t_tick;
                dt = (dt32 > 32'd65535) ? 65535 : longint'(dt32);
                phase = (yaw >> (32 - ANGLE_BITS)) << (32 - ANGLE_BITS);
                s = quarter_sine({34'd0, phase[29:0]});
                c = quarter_sine((64'd1 << 30) - {34'd0, phase[29:0]});
                case (phase[31:30])
                    2'd0: begin sn = s;  cs = c;  end
                    2'd1: begin sn = c;  cs = -s; end
                    2'd2: begin sn = -s; cs = -c; end
                    default: begin sn = -c; cs = s; end
                endcase
                p  = lin_v * dt;
                xa = xa + 48'((p * cs) >>> 30);
                ya = ya + 48'((p * sn) >>> 30);
                yaw_step = ang_v * dt;
                yaw = yaw + yaw_step[31:0];
                t_tick = ts;
            end
            r.x   = xa;
            r.y   = ya;
            r.hd  = yaw;
            r.lin = 18'(lin_v);
            r.ang = 24'(ang_v);
            r.tmo = latch;
            pending_q.push_back(r);
        endfunction

        function void check_result(odom_t act);
            odom_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, act.x, act.y);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (act.x !== e.x) begin
                $display("%0t: pos_x exp %0d act %0d", $time, e.x, act.x);
                errors++;
            end
            if (act.y !== e.y) begin
                $display("%0t: pos_y exp %0d act %0d", $time, e.y, act.y);
                errors++;
            end
            if (act.hd !== e.hd) begin
                $display("%0t: heading exp %0h act %0h", $time, e.hd, act.hd);
                errors++;
            end
            if (act.lin !== e.lin) begin
                $display("%0t: linear_velocity exp %0d act %0d", $time, e.lin, act.lin);
                errors++;
            end
            if (act.ang !== e.ang) begin
                $display("%0t: angular_velocity exp %0d act %0d", $time, e.ang, act.ang);
                errors++;
            end
            if (act.tmo !== e.tmo) begin
                $display("%0t: timed_out exp %0b act %0b", $time, e.tmo, act.tmo);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mbos_pkg::CFG_ADDR_W-1:0] paddr;
    logic [mbos_pkg::CFG_DATA_W-1:0] pwdata;
    logic [mbos_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    mbos_in_if  in_ch ();
    mbos_out_if out_ch ();

    odom_scoreboard odom_sb;
    bit [31:0]      clock_now;
    int             ready_hold;
    bit             calm;

    mobile_base_odometry_slew #(
        .ANGLE_INDEX_BITS (ANGLE_BITS),
        .COMMAND_DT_CAP   (DT_CAP)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Result receiver with random stalls and an externally requested long hold.
    initial
    begin
        int burst;
        burst = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0) begin
                ready_hold--;
                out_ch.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(0, 11);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        odom_t act;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            act.x   = out_ch.pos_x;
            act.y   = out_ch.pos_y;
            act.hd  = out_ch.heading;
            act.lin = out_ch.linear_velocity;
            act.ang = out_ch.angular_velocity;
            act.tmo = out_ch.timed_out;
            odom_sb.check_result(act);
        end
    end

    task automatic reg_write(logic [1:0] idx, bit [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        odom_sb.set_reg(idx, val);
    endtask

    // Withdraws the last transaction and waits until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (odom_sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_all(bit [31:0] la, bit [31:0] aa, bit [31:0] tmo);
        drain();
        reg_write(mbos_pkg::CFG_LIN_ACCEL, la);
        reg_write(mbos_pkg::CFG_ANG_ACCEL, aa);
        reg_write(mbos_pkg::CFG_TIMEOUT, tmo);
    endtask

    // Offers one transaction; returns at the edge that accepted it.
    task automatic send_item(bit kind, bit [31:0] step, bit [17:0] tl, bit [23:0] ta);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        clock_now = clock_now + step;
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= kind;
        in_ch.timestamp      <= clock_now;
        in_ch.target_linear  <= tl;
        in_ch.target_angular <= ta;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        odom_sb.note_item(kind, clock_now, tl, ta);
    endtask

    function automatic bit [31:0] rand_step();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return 32'd0;
            2: return $urandom_range(60000, 70000);
            3: return $urandom_range(400, 2000);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    task automatic random_run(int count);
        bit [17:0] tl;
        bit [23:0] ta;
        for (int n = 0; n < count; n++)
        begin
            tl = 18'($urandom);
            ta = 24'($urandom);
            if ($urandom_range(0, 9) == 0)
                tl = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
            if ($urandom_range(0, 9) == 0)
                ta = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            // About three items in ten are commands and the rest ticks, so velocity builds up.
            if ($urandom_range(0, 9) < 3)
                send_item(1'b0, rand_step(), tl, ta);
            else
                send_item(1'b1, rand_step(), tl, ta);
        end
    endtask

    initial
    begin
        odom_sb      = new();
        clock_now    = 32'd0;
        ready_hold   = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.kind   = 1'b0;
        in_ch.timestamp      = '0;
        in_ch.target_linear  = '0;
        in_ch.target_angular = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, zero intervals, caps, timeout entry and exit, wrap.
        send_item(1'b1, 32'd0, 18'h00000, 24'h000000);
        send_item(1'b0, 32'd100, 18'h1FFFF, 24'h7FFFFF);
        send_item(1'b0, 32'd0, 18'h1FFFF, 24'h7FFFFF);
        send_item(1'b0, 32'd5000, 18'h1FFFF, 24'h7FFFFF);
        send_item(1'b1, 32'd200, 18'h0, 24'h0);
        send_item(1'b1, 32'd70000, 18'h0, 24'h0);
        send_item(1'b0, 32'd10, 18'h20000, 24'h800000);
        send_item(1'b0, 32'd600, 18'h20000, 24'h800000);
        send_item(1'b1, 32'd1, 18'h0, 24'h0);
        send_item(1'b1, 32'd300, 18'h0, 24'h0);
        send_item(1'b1, 32'd600, 18'h0, 24'h0);
        send_item(1'b1, 32'd50, 18'h0, 24'h0);
        send_item(1'b0, 32'd1, 18'h00400, 24'h123456);
        send_item(1'b1, 32'd0, 18'h0, 24'h0);
        send_item(1'b0, 32'hFFFF_FF00, 18'h3FC00, 24'hEDCBAA);
        send_item(1'b1, 32'd512, 18'h0, 24'h0);
        send_item(1'b1, 32'd513, 18'h0, 24'h0);
        send_item(1'b0, 32'd3, 18'h00001, 24'hFFFFFF);
        send_item(1'b1, 32'hFFFF_FFFF, 18'h0, 24'h0);

        random_run(250);

        set_all(32'd0, 32'd0, 32'd0);
        random_run(100);

        set_all(32'd65535, 32'd16777215, 32'd65535);
        ready_hold = 400;
        random_run(250);

        set_all($urandom_range(1, 4000), $urandom_range(1, 1 << 22), $urandom_range(100, 3000));
        random_run(250);

        set_all(32'd1024, 32'd4194304, 32'd512);
        calm = 1'b1;
        random_run(180);

        drain();
        repeat (300) @(posedge clk);
        $display("Covered %0d commands and %0d ticks, %0d timeout entries, five register settings.",
                 odom_sb.n_cmd, odom_sb.n_tick, odom_sb.n_tmo);
        if (odom_sb.errors == 0 && odom_sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
